// ===== design/rva_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rva_pkg;
	localparam int CW = 32;
	localparam int AW = 20;
	localparam int STEPS = 30;
	localparam logic signed [35:0] TWO_PI_Q32 = 36'sd26986075409;
	localparam logic signed [35:0] PI_Q32 = 36'sd13493037705;
	localparam logic signed [35:0] HALF_PI_Q32 = 36'sd6746518852;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;

	typedef struct packed {
		logic signed [CW-1:0] vec_x;
		logic signed [CW-1:0] vec_y;
		logic signed [CW-1:0] vec_z;
		logic signed [CW-1:0] axis_x;
		logic signed [CW-1:0] axis_y;
		logic signed [CW-1:0] axis_z;
		logic signed [AW-1:0] angle;
	} in_t;

	typedef struct packed {
		logic signed [CW-1:0] rot_x;
		logic signed [CW-1:0] rot_y;
		logic signed [CW-1:0] rot_z;
		logic axis_was_zero;
	} out_t;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: atan_q30 = 34'sd843314857;
			5'd1: atan_q30 = 34'sd497837829;
			5'd2: atan_q30 = 34'sd263043837;
			5'd3: atan_q30 = 34'sd133525159;
			5'd4: atan_q30 = 34'sd67021687;
			5'd5: atan_q30 = 34'sd33543516;
			5'd6: atan_q30 = 34'sd16775851;
			5'd7: atan_q30 = 34'sd8388437;
			5'd8: atan_q30 = 34'sd4194283;
			5'd9: atan_q30 = 34'sd2097149;
			default: atan_q30 = 34'sd1 <<< (30 - i);
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== design/rva_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none
// One row of the rotation: R[i][j]*vec_j summed, rounded and saturated.
module rva_lane (
	input  wire logic clk,
	input  wire logic signed [33:0] r0,
	input  wire logic signed [33:0] r1,
	input  wire logic signed [33:0] r2,
	input  wire logic signed [31:0] v0,
	input  wire logic signed [31:0] v1,
	input  wire logic signed [31:0] v2,
	output logic signed [31:0] res
);
	logic signed [65:0] p0_s1, p1_s1, p2_s1;
	logic signed [67:0] sum;
	logic signed [37:0] sh;

	always_ff @(posedge clk) begin
		p0_s1 <= r0 * v0;
		p1_s1 <= r1 * v1;
		p2_s1 <= r2 * v2;
	end

	always_comb begin
		sum = 68'(p0_s1) + 68'(p1_s1) + 68'(p2_s1) + 68'sd536870912;
		sh = 38'(sum >>> 30);
		if (sh > 38'sd2147483647) res = 32'sh7fffffff;
		else if (sh < -38'sd2147483648) res = 32'sh80000000;
		else res = sh[31:0];
	end
endmodule
`default_nettype wire

// ===== design/rotate_vector_about_axis.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Rotates a Q16.16 vector about an arbitrary axis by a Q3.16 angle. A new
// transaction may start every cycle (busy stays low). done goes high with the
// result once it has passed the pipeline: one stage for axis scaling and angle
// reduction, 40 stages that run the 30-step CORDIC beside the square root, 32
// divider stages, two matrix stages and the lane multiply stage.
// The receiver cannot stall; results must be taken when done is high.
module rotate_vector_about_axis (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire rva_pkg::in_t payload,
	output logic done,
	output rva_pkg::out_t result
);
	localparam int NS = 40;   // pipeline depth of sqrt stage
	localparam int ND = 32;   // divider stages
	localparam int LAT = 1 + NS + ND + 3;

	assign busy = 1'b0;

	// Stage 1: normalize magnitudes, reduce angle.
	logic [31:0] m [3];
	logic [31:0] top;
	logic [5:0] bits;
	logic [29:0] nm [3];
	logic signed [36:0] r0, r1;
	logic signed [35:0] rr;
	logic flip;

	always_comb begin
		m[0] = payload.axis_x[31] ? 32'(-payload.axis_x) : payload.axis_x;
		m[1] = payload.axis_y[31] ? 32'(-payload.axis_y) : payload.axis_y;
		m[2] = payload.axis_z[31] ? 32'(-payload.axis_z) : payload.axis_z;
		top = m[0] | m[1] | m[2];
		bits = 6'd0;
		for (int i = 0; i < 32; i++) if (top[i]) bits = 6'(i + 1);
		for (int i = 0; i < 3; i++)
			nm[i] = (bits > 6'd30) ? 30'(m[i] >> (bits - 6'd30))
				: 30'(m[i] << (6'd30 - bits));
		r0 = 37'(payload.angle) <<< 16;
		if (r0 < 0) r0 = r0 + 37'(rva_pkg::TWO_PI_Q32);
		if (r0 > 37'(rva_pkg::PI_Q32)) r0 = r0 - 37'(rva_pkg::TWO_PI_Q32);
		if (r0 > 37'(rva_pkg::PI_Q32)) r0 = r0 - 37'(rva_pkg::TWO_PI_Q32);
		r1 = r0;
		flip = 1'b0;
		if (r0 > 37'(rva_pkg::HALF_PI_Q32)) begin
			r1 = 37'(rva_pkg::PI_Q32) - r0; flip = 1'b1;
		end else if (r0 < -37'(rva_pkg::HALF_PI_Q32)) begin
			r1 = -37'(rva_pkg::PI_Q32) - r0; flip = 1'b1;
		end
		rr = 36'(r1);
	end

	logic [29:0] nm_s1 [3];
	logic [2:0] neg_s1;
	logic zero_s1, flip_s1;
	logic signed [33:0] z_s1;
	logic [61:0] ssq;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) nm_s1[i] <= nm[i];
		neg_s1 <= {payload.axis_z[31], payload.axis_y[31], payload.axis_x[31]};
		zero_s1 <= (top == 32'd0);
		flip_s1 <= flip;
		z_s1 <= 34'(rr >>> 2);
	end

	assign ssq = 62'(nm_s1[0]) * nm_s1[0] + 62'(nm_s1[1]) * nm_s1[1];

	// Stages: CORDIC and sqrt side by side, at most one step per stage.
	logic signed [33:0] cx [NS+1], cy [NS+1], cz [NS+1];
	logic [61:0] sn [NS+1], sres [NS+1], sbit [NS+1];
	logic [29:0] mg [NS+1][3];
	logic [2:0] ng [NS+1];
	logic zr [NS+1], fl [NS+1];
	logic [61:0] sq3;

	assign sq3 = ssq + 62'(nm_s1[2]) * nm_s1[2];

	always_comb begin
		cx[0] = rva_pkg::GAIN_Q30; cy[0] = '0; cz[0] = z_s1;
		sn[0] = sq3; sres[0] = '0; sbit[0] = 62'd1 << 60;
		for (int i = 0; i < 3; i++) mg[0][i] = nm_s1[i];
		ng[0] = neg_s1; zr[0] = zero_s1; fl[0] = flip_s1;
	end

	for (genvar g = 0; g < NS; g++) begin : g_st
		logic signed [33:0] nx, ny, nz;
		logic [61:0] nn, nr;
		always_comb begin
			nx = cx[g]; ny = cy[g]; nz = cz[g];
			if (g < rva_pkg::STEPS) begin
				if (cz[g] >= 0) begin
					nx = cx[g] - (cy[g] >>> g); ny = cy[g] + (cx[g] >>> g);
					nz = cz[g] - rva_pkg::atan_q30(5'(g));
				end else begin
					nx = cx[g] + (cy[g] >>> g); ny = cy[g] - (cx[g] >>> g);
					nz = cz[g] + rva_pkg::atan_q30(5'(g));
				end
			end
			nn = sn[g]; nr = sres[g];
			if (g < 31) begin
				if (sn[g] >= sres[g] + sbit[g]) begin
					nn = sn[g] - (sres[g] + sbit[g]); nr = (sres[g] >> 1) + sbit[g];
				end else nr = sres[g] >> 1;
			end
		end
		always_ff @(posedge clk) begin
			cx[g+1] <= nx; cy[g+1] <= ny; cz[g+1] <= nz;
			sn[g+1] <= nn; sres[g+1] <= nr;
			sbit[g+1] <= (g < 31) ? (sbit[g] >> 2) : sbit[g];
			mg[g+1] <= mg[g]; ng[g+1] <= ng[g]; zr[g+1] <= zr[g]; fl[g+1] <= fl[g];
		end
	end

	// Divider: q = (mag*2^30 + len/2) / len, restoring, one bit a stage.
	logic [31:0] len;
	assign len = sres[NS][31:0];
	logic [61:0] dn [ND+1][3];
	logic [61:0] dr [ND+1][3];
	logic [31:0] dl [ND+1];
	logic signed [33:0] dc [ND+1], ds [ND+1];
	logic [2:0] dg [ND+1];
	logic dz [ND+1];

	// The quotient fits 32 bits, so the dividend's upper 30 bits are below len
	// and start out as the remainder; the stages develop quotient bits 31 to 0.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dn[0][i] = (62'(mg[NS][i]) << 30) + 62'(len >> 1);
			dr[0][i] = dn[0][i] >> 32;
		end
		dl[0] = (len == 0) ? 32'd1 : len;
		dc[0] = fl[NS] ? -cx[NS] : cx[NS];
		ds[0] = cy[NS]; dg[0] = ng[NS]; dz[0] = zr[NS];
	end

	for (genvar g = 0; g < ND; g++) begin : g_dv
		logic [61:0] qn [3], rn [3];
		logic [62:0] tr [3];
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				tr[i] = {dr[g][i], dn[g][i][31 - g]};
				qn[i] = dn[g][i];
				if (tr[i] >= 63'(dl[g])) begin
					rn[i] = 62'(tr[i] - 63'(dl[g])); qn[i][31 - g] = 1'b1;
				end else begin
					rn[i] = 62'(tr[i]); qn[i][31 - g] = 1'b0;
				end
			end
		end
		always_ff @(posedge clk) begin
			dn[g+1] <= qn; dr[g+1] <= rn; dl[g+1] <= dl[g];
			dc[g+1] <= dc[g]; ds[g+1] <= ds[g]; dg[g+1] <= dg[g]; dz[g+1] <= dz[g];
		end
	end

	// Matrix build: two multiply stages.
	logic signed [33:0] u [3];
	always_comb
		for (int i = 0; i < 3; i++) begin
			u[i] = dz[ND] ? 34'sd0 : (dg[ND][i] ? -34'(dn[ND][i][31:0]) : 34'(dn[ND][i][31:0]));
		end

	logic signed [67:0] uu_p [3][3], us_p [3];
	logic signed [33:0] uu_s2 [3][3], us_s2 [3], c_s2, t_s2;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) uu_p[i][j] = u[i] * u[j] + 68'sd536870912;
			us_p[i] = u[i] * ds[ND] + 68'sd536870912;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) uu_s2[i][j] <= 34'(uu_p[i][j] >>> 30);
			us_s2[i] <= 34'(us_p[i] >>> 30);
		end
		c_s2 <= dc[ND]; t_s2 <= rva_pkg::ONE_Q30 - dc[ND];
	end

	logic signed [33:0] R [3][3];
	logic signed [67:0] tp [3][3];
	always_comb
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) tp[i][j] = uu_s2[i][j] * t_s2 + 68'sd536870912;

	logic signed [33:0] m_s3 [3][3], us_s3 [3], c_s3;
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) m_s3[i][j] <= 34'(tp[i][j] >>> 30);
		us_s3 <= us_s2; c_s3 <= c_s2;
	end

	always_comb begin
		R[0][0] = c_s3 + m_s3[0][0]; R[1][1] = c_s3 + m_s3[1][1];
		R[2][2] = c_s3 + m_s3[2][2];
		R[0][1] = m_s3[0][1] - us_s3[2]; R[0][2] = m_s3[0][2] + us_s3[1];
		R[1][0] = m_s3[1][0] + us_s3[2]; R[1][2] = m_s3[1][2] - us_s3[0];
		R[2][0] = m_s3[2][0] - us_s3[1]; R[2][1] = m_s3[2][1] + us_s3[0];
	end

	// Vector and zero flag delay line matching the pipeline.
	localparam int VD = 1 + NS + ND + 2;
	logic signed [31:0] vd [VD][3];
	logic zd [3];
	logic [LAT-1:0] vld;
	always_ff @(posedge clk) begin
		vd[0][0] <= payload.vec_x; vd[0][1] <= payload.vec_y; vd[0][2] <= payload.vec_z;
		for (int k = 0; k < VD - 1; k++) vd[k+1] <= vd[k];
		zd[0] <= dz[ND]; zd[1] <= zd[0]; zd[2] <= zd[1];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld <= '0;
		else vld <= {vld[LAT-2:0], start};
	end

	rva_lane u_l0 (.clk(clk), .r0(R[0][0]), .r1(R[0][1]), .r2(R[0][2]),
		.v0(vd[VD-1][0]), .v1(vd[VD-1][1]), .v2(vd[VD-1][2]), .res(result.rot_x));
	rva_lane u_l1 (.clk(clk), .r0(R[1][0]), .r1(R[1][1]), .r2(R[1][2]),
		.v0(vd[VD-1][0]), .v1(vd[VD-1][1]), .v2(vd[VD-1][2]), .res(result.rot_y));
	rva_lane u_l2 (.clk(clk), .r0(R[2][0]), .r1(R[2][1]), .r2(R[2][2]),
		.v0(vd[VD-1][0]), .v1(vd[VD-1][1]), .v2(vd[VD-1][2]), .res(result.rot_z));

	assign result.axis_was_zero = zd[2];
	assign done = vld[LAT-1];
endmodule
`default_nettype wire
